// ===== rtl/jse_pkg.sv =====
`default_nettype none

package jse_pkg;

    // widths and sizes
    localparam int JSE_BYTE_W      = 8;
    localparam int JSE_STEP_W      = 3;
    localparam int JSE_QUEUE_DEPTH = 4;

    // character codes
    localparam logic [JSE_BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [JSE_BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [JSE_BYTE_W-1:0] CH_BS        = 8'h08;
    localparam logic [JSE_BYTE_W-1:0] CH_FF        = 8'h0C;
    localparam logic [JSE_BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [JSE_BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [JSE_BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [JSE_BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [JSE_BYTE_W-1:0] CH_LOW_B     = 8'h62;
    localparam logic [JSE_BYTE_W-1:0] CH_LOW_F     = 8'h66;
    localparam logic [JSE_BYTE_W-1:0] CH_LOW_N     = 8'h6E;
    localparam logic [JSE_BYTE_W-1:0] CH_LOW_R     = 8'h72;
    localparam logic [JSE_BYTE_W-1:0] CH_LOW_T     = 8'h74;
    localparam logic [JSE_BYTE_W-1:0] CH_LOW_U     = 8'h75;
    localparam logic [JSE_BYTE_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [JSE_BYTE_W-1:0] CH_HEX_ALPHA = 8'h57;  // 'a' minus ten

    // positions within a hex escape run
    localparam logic [JSE_STEP_W-1:0] STEP_FIRST  = 3'd0;
    localparam logic [JSE_STEP_W-1:0] STEP_U      = 3'd1;
    localparam logic [JSE_STEP_W-1:0] STEP_ZERO_A = 3'd2;
    localparam logic [JSE_STEP_W-1:0] STEP_ZERO_B = 3'd3;
    localparam logic [JSE_STEP_W-1:0] STEP_HI     = 3'd4;
    localparam logic [JSE_STEP_W-1:0] STEP_LO     = 3'd5;

    // kind of escape for one byte
    typedef enum logic [1:0] {
        KIND_PASS  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_HEX   = 2'd2
    } kind_t;

    // one classified byte in the queue
    typedef struct packed {
        kind_t                 kind;
        logic [JSE_BYTE_W-1:0] data;  // raw byte, or escape letter for short escapes
    } entry_t;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    // one output character with its end marker
    typedef struct packed {
        logic [JSE_BYTE_W-1:0] ch;
        logic                  last;
    } char_sel_t;

    // nibble to lower-case hex digit
    function automatic logic [JSE_BYTE_W-1:0] jse_hex_digit(input logic [3:0] n);
        logic [JSE_BYTE_W-1:0] wide;
        wide = {4'h0, n};
        if (n < 4'd10)
        begin
            return CH_ZERO + wide;
        end
        return CH_HEX_ALPHA + wide;
    endfunction

    // character at a given position of an entry's run
    function automatic char_sel_t jse_char_at(input entry_t e, input logic [JSE_STEP_W-1:0] step);
        char_sel_t r;
        r.ch   = CH_BACKSLASH;
        r.last = 1'b0;
        case (e.kind)
            KIND_PASS:
            begin
                r.ch   = e.data;
                r.last = 1'b1;
            end
            KIND_SHORT:
            begin
                if (step != STEP_FIRST)
                begin
                    r.ch   = e.data;
                    r.last = 1'b1;
                end
            end
            KIND_HEX:
            begin
                case (step)
                    STEP_FIRST:  r.ch = CH_BACKSLASH;
                    STEP_U:      r.ch = CH_LOW_U;
                    STEP_ZERO_A: r.ch = CH_ZERO;
                    STEP_ZERO_B: r.ch = CH_ZERO;
                    STEP_HI:     r.ch = jse_hex_digit(e.data[7:4]);
                    default:
                    begin
                        r.ch   = jse_hex_digit(e.data[3:0]);
                        r.last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                r.ch   = e.data;
                r.last = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jse_front.sv =====
`default_nettype none

module jse_front
    import jse_pkg::*;
(
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [JSE_BYTE_W-1:0] in_byte,
    input  wire logic                  q_full,
    output logic                       push,
    output entry_t                     push_entry
);

    // take a byte whenever the queue has room
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // classify the byte and pick the escape letter
    always_comb
    begin
        push_entry.kind = KIND_PASS;
        push_entry.data = in_byte;
        case (in_byte) inside
            CH_QUOTE, CH_BACKSLASH:
            begin
                push_entry.kind = KIND_SHORT;
            end
            CH_BS:
            begin
                push_entry.kind = KIND_SHORT;
                push_entry.data = CH_LOW_B;
            end
            CH_FF:
            begin
                push_entry.kind = KIND_SHORT;
                push_entry.data = CH_LOW_F;
            end
            CH_LF:
            begin
                push_entry.kind = KIND_SHORT;
                push_entry.data = CH_LOW_N;
            end
            CH_CR:
            begin
                push_entry.kind = KIND_SHORT;
                push_entry.data = CH_LOW_R;
            end
            CH_TAB:
            begin
                push_entry.kind = KIND_SHORT;
                push_entry.data = CH_LOW_T;
            end
            [8'h00:8'h1F]:
            begin
                push_entry.kind = KIND_HEX;
            end
            default:
            begin
                push_entry.kind = KIND_PASS;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/jse_queue.sv =====
`default_nettype none

module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = JSE_QUEUE_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output logic        full,
    output head_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t            mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // fill count stays within the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue fill count above depth");

    // the back end only takes an entry that is there
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    // pointers stay in step with the fill count
    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

// ===== rtl/jse_back.sv =====
`default_nettype none

module jse_back
    import jse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire head_t                 head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [JSE_BYTE_W-1:0]      out_char,
    output logic                       last_of_run
);

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [JSE_BYTE_W-1:0]   out_char_reg;
    logic [JSE_BYTE_W-1:0]   out_char_next;
    logic                    out_last_reg;
    logic                    out_last_next;
    logic [JSE_STEP_W-1:0]   step_reg;
    logic [JSE_STEP_W-1:0]   step_next;
    logic                    load;
    char_sel_t               sel;

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;

    // output register takes a new character when empty or being drained
    assign load = !out_valid_reg || !out_stall;
    assign sel  = jse_char_at(head.entry, step_reg);
    assign pop  = load && head.valid && sel.last;

    // step through the run of the entry at the queue head
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        step_next      = step_reg;
        if (load)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                out_char_next = sel.ch;
                out_last_next = sel.last;
                step_next     = sel.last ? STEP_FIRST : step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_FIRST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // a run never goes past the hex escape length
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LO)
        else $error("run position out of range");

    // a run in progress keeps its entry at the queue head
    a_step_head: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != STEP_FIRST) |-> head.valid)
        else $error("run in progress without a queued entry");

    // a transfer that is not the end of a run is followed by the next character
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !out_last_reg) |=> out_valid_reg)
        else $error("run broken before its last character");

endmodule

`default_nettype wire

// ===== rtl/json_string_escaper_core.sv =====
// an accepted byte is written into the queue, and its first character is then loaded into the output register
// throughput: one byte per cycle for pass-through bytes while out_stall is low; short escapes emit
// two characters and hex escapes six, each one a transfer of the single-character output register
// a four-entry queue between classifier and sequencer absorbs output stalls
// reset: asynchronous, active low; clears queue pointers, run position and out_valid
`default_nettype none

module json_string_escaper_core
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = JSE_QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [JSE_BYTE_W-1:0] in_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [JSE_BYTE_W-1:0]      out_char,
    output logic                       last_of_run
);

    logic   q_full;
    logic   push;
    logic   pop;
    entry_t push_entry;
    head_t  head;

    // classify incoming bytes
    jse_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head       (head)
    );

    // emit the escaped run one character per transfer
    jse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
